// ----- hdl/scmm_pkg.sv -----
// ----------------------------------------------------------------------------
// scmm_pkg
// Shared types, sizes and helpers for the coordinate-list matrix multiplier
// ----------------------------------------------------------------------------
package scmm_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // row in the lowest bits, value in the highest
  typedef struct packed {
    logic signed [15:0] value;
    logic        [15:0] col;
    logic        [15:0] row;
  } entry_t;

  typedef enum logic {
    SORT_IDLE,
    SORT_RUN
  } sort_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT,
    ST_ROW,
    ST_COL,
    ST_MERGE,
    ST_PUSH,
    ST_SKIPCOL,
    ST_SKIPROW,
    ST_FINISH
  } state_t;

  // strict ordering, row-major or column-major
  function automatic logic precedes(entry_t x, entry_t y, logic by_col);
    logic [15:0] x1, x2, y1, y2;
    x1 = by_col ? x.col : x.row;
    x2 = by_col ? x.row : x.col;
    y1 = by_col ? y.col : y.row;
    y2 = by_col ? y.row : y.col;
    if (x1 != y1) return x1 < y1;
    return x2 < y2;
  endfunction

endpackage

// ----- hdl/scmm_store.sv -----
// ----------------------------------------------------------------------------
// scmm_store
// Entry store of one matrix with an in-place stable bubble sort engine
// ----------------------------------------------------------------------------
module scmm_store import scmm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_en,
  input  entry_t           load_entry,
  input  logic             clear,
  input  logic             sort_start,
  input  logic             by_col,
  output logic             sort_busy,
  output logic             full,
  output logic [CNT_W-1:0] count,
  input  logic [IDX_W-1:0] rd_addr0,
  output entry_t           rd_data0,
  input  logic [IDX_W-1:0] rd_addr1,
  output entry_t           rd_data1
);

  entry_t          ent [MAX_ENTRIES];
  sort_state_t     sstate, sstate_next;
  logic [IDX_W-1:0] k, k_next;
  logic             swapped, swapped_next;
  logic [CNT_W-1:0] k_plus;
  logic [IDX_W-1:0] k_hi;
  logic             step_ok;
  logic             do_swap;

  assign full      = (count == CNT_W'(MAX_ENTRIES));
  assign sort_busy = (sstate == SORT_RUN);
  assign rd_data0  = ent[rd_addr0];
  assign rd_data1  = ent[rd_addr1];
  assign k_plus    = CNT_W'(k) + CNT_W'(1);
  assign k_hi      = k_plus[IDX_W-1:0];
  assign step_ok   = (k_plus < count);
  assign do_swap   = sort_busy && step_ok && precedes(ent[k_hi], ent[k], by_col);

  always_comb begin
    sstate_next  = sstate;
    k_next       = k;
    swapped_next = swapped;
    unique case (sstate)
      SORT_IDLE: begin
        if (sort_start) begin
          sstate_next  = SORT_RUN;
          k_next       = '0;
          swapped_next = 1'b0;
        end
      end
      SORT_RUN: begin
        if (step_ok) begin
          k_next = k_hi;
          if (do_swap) swapped_next = 1'b1;
        end else if (swapped) begin
          k_next       = '0;
          swapped_next = 1'b0;
        end else begin
          sstate_next = SORT_IDLE;
        end
      end
      default: sstate_next = SORT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sstate  <= SORT_IDLE;
      k       <= '0;
      swapped <= 1'b0;
      count   <= '0;
    end else begin
      sstate  <= sstate_next;
      k       <= k_next;
      swapped <= swapped_next;
      if (clear) begin
        count <= '0;
      end else if (load_en && !full) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!clear && load_en && !full) begin
      ent[count[IDX_W-1:0]] <= load_entry;
    end else if (do_swap) begin
      ent[k]    <= ent[k_hi];
      ent[k_hi] <= ent[k];
    end
  end

endmodule

// ----- hdl/sparse_coo_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// sparse_coo_matrix_multiply
// Coordinate-list sparse matrix product C = A x B
// ----------------------------------------------------------------------------
// Input words on s_*: tuser carries the mode. Mode 0 and 1 append one
// (row, col, value) entry to the A or B store; loads into a full store are
// dropped and remembered as the dropped flag. Mode 3 is ignored. Mode 2
// sorts both stores (bubble passes, one compare-and-swap per cycle), then a
// sequencer walks every A row against every B column, one merge step per
// cycle through a single 16x16 multiply-accumulate. s_tready stays low
// throughout a compute. Each nonzero sum leaves on m_* in row then column
// order, the final word with tlast; with no nonzero sum one empty word
// (has_value 0) is sent. Results go through a pending and an output
// register; a stalled receiver holds the sequencer only when both are full
// and a further result is ready, or when the final word is due.
// After the final word is loaded both stores and the dropped flag clear.
// Reset empties both stores and drops any pending output.
// ----------------------------------------------------------------------------
module sparse_coo_matrix_multiply import scmm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // row_index, col_index, entry_value
  input  logic [1:0]  s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // out_row, out_col, out_sum
  output logic [1:0]  m_tuser,  // has_value, dropped
  output logic        m_tlast
);

  state_t           state, state_next;
  logic             in_acc;
  mode_t            in_mode;
  entry_t           in_entry;
  logic             out_free;

  logic             a_load, b_load, a_full, b_full, a_busy, b_busy, clear, sort_start;
  logic [CNT_W-1:0] na, nb;
  entry_t           a_i, a_p, b_j, b_q;
  logic [CNT_W-1:0] i, j, p, q;
  logic [15:0]      row, col;
  logic [31:0]      sum;
  logic             overflow_seen;
  logic             pend_valid;
  logic [15:0]      pend_row, pend_col;
  logic [31:0]      pend_sum;
  logic             merge_go;
  logic signed [31:0] prod;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign in_mode  = mode_t'(s_tuser);
  assign in_entry = s_tdata;
  assign out_free = !m_tvalid || m_tready;

  assign a_load     = in_acc && (in_mode == MODE_LOAD_A);
  assign b_load     = in_acc && (in_mode == MODE_LOAD_B);
  assign sort_start = in_acc && (in_mode == MODE_COMPUTE);
  assign clear      = (state == ST_FINISH) && out_free;

  scmm_store u_a (
    .clk, .rst,
    .load_en(a_load), .load_entry(in_entry), .clear, .sort_start,
    .by_col(1'b0), .sort_busy(a_busy), .full(a_full), .count(na),
    .rd_addr0(i[IDX_W-1:0]), .rd_data0(a_i),
    .rd_addr1(p[IDX_W-1:0]), .rd_data1(a_p)
  );

  scmm_store u_b (
    .clk, .rst,
    .load_en(b_load), .load_entry(in_entry), .clear, .sort_start,
    .by_col(1'b1), .sort_busy(b_busy), .full(b_full), .count(nb),
    .rd_addr0(j[IDX_W-1:0]), .rd_data0(b_j),
    .rd_addr1(q[IDX_W-1:0]), .rd_data1(b_q)
  );

  assign merge_go = (p < na) && (a_p.row == row) && (q < nb) && (b_q.col == col);
  assign prod     = a_p.value * b_q.value;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (sort_start) state_next = ST_SORT;
      ST_SORT:    if (!a_busy && !b_busy) state_next = ST_ROW;
      ST_ROW:     state_next = (i < na) ? ST_COL : ST_FINISH;
      ST_COL:     state_next = (j < nb) ? ST_MERGE : ST_SKIPROW;
      ST_MERGE:   if (!merge_go) state_next = (sum != '0) ? ST_PUSH : ST_SKIPCOL;
      ST_PUSH:    if (!pend_valid || out_free) state_next = ST_SKIPCOL;
      ST_SKIPCOL: if (!((j < nb) && (b_j.col == col))) state_next = ST_COL;
      ST_SKIPROW: if (!((i < na) && (a_i.row == row))) state_next = ST_ROW;
      ST_FINISH:  if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      overflow_seen <= 1'b0;
      pend_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (clear) begin
        overflow_seen <= 1'b0;
      end else if ((a_load && a_full) || (b_load && b_full)) begin
        overflow_seen <= 1'b1;
      end
      if (clear || ((state == ST_PUSH) && pend_valid && out_free)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (clear) begin
        pend_valid <= 1'b0;
      end else if ((state == ST_PUSH) && (!pend_valid || out_free)) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_SORT: i <= '0;
      ST_ROW: begin
        row <= a_i.row;
        j   <= '0;
      end
      ST_COL: begin
        col <= b_j.col;
        p   <= i;
        q   <= j;
        sum <= '0;
      end
      ST_MERGE: begin
        if (merge_go) begin
          if (a_p.col < b_q.row) begin
            p <= p + CNT_W'(1);
          end else if (a_p.col > b_q.row) begin
            q <= q + CNT_W'(1);
          end else begin
            sum <= sum + prod;
            p   <= p + CNT_W'(1);
            q   <= q + CNT_W'(1);
          end
        end
      end
      ST_PUSH: begin
        if (!pend_valid || out_free) begin
          pend_row <= row;
          pend_col <= col;
          pend_sum <= sum;
        end
        if (pend_valid && out_free) begin
          m_tdata <= {pend_sum, pend_col, pend_row};
          m_tuser <= {overflow_seen, 1'b1};
          m_tlast <= 1'b0;
        end
      end
      ST_SKIPCOL: if ((j < nb) && (b_j.col == col)) j <= j + CNT_W'(1);
      ST_SKIPROW: if ((i < na) && (a_i.row == row)) i <= i + CNT_W'(1);
      ST_FINISH: begin
        if (out_free) begin
          m_tdata <= pend_valid ? {pend_sum, pend_col, pend_row} : 64'd0;
          m_tuser <= {overflow_seen, pend_valid};
          m_tlast <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/scmm_checker.sv -----
// ----------------------------------------------------------------------------
// scmm_checker
// Port-level checks of the result stream
// ----------------------------------------------------------------------------
module scmm_checker import scmm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word withdrawn while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("empty result not marked last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == 64'd0))
    else $error("empty result carries data");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[63:32] != 32'd0))
    else $error("zero sum emitted");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind sparse_coo_matrix_multiply scmm_checker u_scmm_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);

// ----- sim/tb_sparse_coo_matrix_multiply.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_coo_matrix_multiply
// Loads random coordinate-list entries into both stores, issues computes and
// checks every product word against an in-bench sparse product predictor
// ----------------------------------------------------------------------------
module tb_sparse_coo_matrix_multiply;
  import scmm_pkg::*;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] data;
  } load_word_t;

  typedef struct packed {
    logic [15:0] row;
    logic [15:0] col;
    logic [31:0] sum;
    logic        has_value;
    logic        dropped;
    logic        last;
  } product_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  load_word_t pending_words[$];
  product_t   expected_products[$];
  entry_t     a_store[MAX_ENTRIES];
  entry_t     b_store[MAX_ENTRIES];
  int         a_used = 0;
  int         b_used = 0;
  bit         overflow = 1'b0;
  int         mismatches = 0;
  bit         quiet = 1'b0;
  bit         hold_sender = 1'b0;

  sparse_coo_matrix_multiply u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void queue_word(load_word_t lw);
    pending_words.insert(pending_words.size(), lw);
  endfunction

  function automatic bit goes_first(entry_t x, entry_t y, bit by_col);
    logic [15:0] xk, xm, yk, ym;
    xk = by_col ? x.col : x.row;
    xm = by_col ? x.row : x.col;
    yk = by_col ? y.col : y.row;
    ym = by_col ? y.row : y.col;
    if (xk != yk) return xk < yk;
    return xm < ym;
  endfunction

  task automatic predict_product();
    entry_t a[MAX_ENTRIES];
    entry_t b[MAX_ENTRIES];
    entry_t key;
    int i, j, p, q, k, n;
    logic [15:0] row, col;
    logic [31:0] acc;
    product_t w;
    a = a_store;
    b = b_store;
    for (i = 1; i < a_used; i++) begin
      key = a[i];
      k = i;
      while (k > 0 && goes_first(key, a[k-1], 1'b0)) begin
        a[k] = a[k-1];
        k--;
      end
      a[k] = key;
    end
    for (i = 1; i < b_used; i++) begin
      key = b[i];
      k = i;
      while (k > 0 && goes_first(key, b[k-1], 1'b1)) begin
        b[k] = b[k-1];
        k--;
      end
      b[k] = key;
    end
    n = 0;
    i = 0;
    while (i < a_used) begin
      row = a[i].row;
      j = 0;
      while (j < b_used) begin
        col = b[j].col;
        acc = '0;
        p = i;
        q = j;
        while (p < a_used && a[p].row == row && q < b_used && b[q].col == col) begin
          if (a[p].col < b[q].row) p++;
          else if (a[p].col > b[q].row) q++;
          else begin
            acc += 32'(signed'(a[p].value) * signed'(b[q].value));
            p++;
            q++;
          end
        end
        if (acc != 0) begin
          w = '{row, col, acc, 1'b1, overflow, 1'b0};
          expected_products.insert(expected_products.size(), w);
          n++;
        end
        while (j < b_used && b[j].col == col) j++;
      end
      while (i < a_used && a[i].row == row) i++;
    end
    if (n == 0) begin
      w = '{16'd0, 16'd0, 32'd0, 1'b0, overflow, 1'b0};
      expected_products.insert(expected_products.size(), w);
    end
    expected_products[$].last = 1'b1;
    a_used = 0;
    b_used = 0;
    overflow = 1'b0;
  endtask

  task automatic apply_word(load_word_t lw);
    case (mode_t'(lw.mode))
      MODE_LOAD_A: begin
        if (a_used < MAX_ENTRIES) a_store[a_used++] = lw.data;
        else overflow = 1'b1;
      end
      MODE_LOAD_B: begin
        if (b_used < MAX_ENTRIES) b_store[b_used++] = lw.data;
        else overflow = 1'b1;
      end
      MODE_COMPUTE: predict_product();
      default: ;
    endcase
  endtask

  function automatic load_word_t make_word(mode_t m, int span, bit wide_value);
    load_word_t lw;
    entry_t e;
    e.row = 16'($urandom_range(0, span));
    e.col = 16'($urandom_range(0, span));
    e.value = wide_value ? 16'($urandom) : 16'($urandom_range(0, 6) - 3);
    lw.mode = m;
    lw.data = e;
    return lw;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_words.size() > 0 && !hold_sender && (quiet || $urandom_range(0, 99) >= 34))
      begin
        {s_tuser, s_tdata} <= pending_words.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) apply_word({s_tuser, s_tdata});
  end

  // monitor
  always @(posedge clk) begin
    product_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(0, 99) >= 34);
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[63:32], m_tuser[0], m_tuser[1],
                m_tlast};
        if (expected_products.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got);
        end else begin
          want = expected_products.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %h got %h", want, got);
          end
        end
      end
    end
  end

  initial begin
    load_word_t lw;
    int k, na, nb, span;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty product, field extremes, full stores, dropped loads, mode 3
    // entry words are {value, col, row}
    queue_word('{MODE_COMPUTE, 48'd0});
    queue_word('{MODE_LOAD_A, {16'h8000, 16'hFFFF, 16'hFFFF}});
    queue_word('{MODE_LOAD_B, {16'h8000, 16'hFFFF, 16'hFFFF}});
    queue_word('{MODE_NONE, 48'hFFFF_FFFF_FFFF});
    queue_word('{MODE_COMPUTE, 48'hFFFF_FFFF_FFFF});
    for (k = 0; k < 9; k++) begin
      queue_word('{MODE_LOAD_A, {16'h7FFF, 16'(k % 2), 16'd0}});
      queue_word('{MODE_LOAD_B, {16'h7FFF, 16'(k % 3), 16'(k % 2)}});
    end
    queue_word('{MODE_COMPUTE, 48'd0});
    queue_word('{MODE_LOAD_A, {16'd1, 16'd2, 16'd1}});
    queue_word('{MODE_LOAD_B, {16'd5, 16'd4, 16'd3}});
    queue_word('{MODE_COMPUTE, 48'd0});

    // random well-formed batches, some noise, a quiet stretch
    while (pending_words.size() < 200) begin
      na = $urandom_range(0, 10);
      nb = $urandom_range(0, 10);
      span = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(1, 4);
      for (k = 0; k < na + nb; k++) begin
        lw = make_word((k < na) ? MODE_LOAD_A : MODE_LOAD_B, span, $urandom_range(0, 1));
        if ($urandom_range(0, 5) == 0) lw = make_word(mode_t'($urandom_range(0, 1)), 65535, 1);
        queue_word(lw);
        if ($urandom_range(0, 29) == 0) queue_word('{MODE_NONE, 48'($urandom)});
      end
      lw = make_word(MODE_COMPUTE, 65535, 1);
      queue_word(lw);
    end
    queue_word('{MODE_COMPUTE, 48'd0});

    wait (pending_words.size() < 150);
    quiet = 1'b1;
    wait (pending_words.size() < 100);
    quiet = 1'b0;
    wait (pending_words.size() < 60);
    hold_sender = 1'b1;
    wait (expected_products.size() == 0);
    @(posedge clk);
    hold_sender = 1'b0;

    wait (pending_words.size() == 0 && !s_tvalid);
    wait (expected_products.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_products.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
